@@ rtl/pig_pkg.sv @@
`timescale 1ns / 1ps

package pig_pkg;

  // Default configuration
  localparam int unsigned PIG_GAMMA_INDEX_BITS   = 12;
  localparam int unsigned PIG_LUMA_FRACTION_BITS = 16;

  // Pixel channel width
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned TDATA_W = 3 * PIX_W;

  // Mode register codes
  typedef enum logic {
    MODE_INVERT = 1'b0,
    MODE_GRAY   = 1'b1
  } pig_mode_e;

  // Linear segment: out = floor(Y * 16473 / (5 * 2^F)), the /5 done as *205 >> 10
  localparam int unsigned LIN_MUL      = 16473;
  localparam int unsigned LIN_MUL_W    = 15;
  localparam int unsigned DIV5_MUL     = 205;
  localparam int unsigned DIV5_SHIFT   = 10;
  localparam int unsigned LIN_X_W      = 10;

  // Threshold table: widest gamma index is 2^16, needing 17 bits
  localparam int unsigned THR_W = 17;
  typedef logic [255:0][THR_W-1:0] pig_thr_t;

  // (o*1000 + 14025) / 269025 is the normalised sRGB level
  localparam longint unsigned GAM_RATIO_DEN = 269025;
  localparam longint unsigned MANT_MIN      = 64'd1 << 31;

  // Normalised number: mantissa in [2^31, 2^32) times 2^e
  typedef struct packed {
    logic        [31:0] m;
    logic signed [31:0] e;
  } pig_xnum_t;

  function automatic pig_xnum_t pig_xmul(input pig_xnum_t a, input pig_xnum_t b);
    logic [63:0] p;
    pig_xnum_t   r;
    p = 64'(a.m) * 64'(b.m);
    if (p[63]) begin
      r.m = p[63:32];
      r.e = $signed(a.e) + $signed(b.e) + 32'sd32;
    end else begin
      r.m = p[62:31];
      r.e = $signed(a.e) + $signed(b.e) + 32'sd31;
    end
    return r;
  endfunction

  function automatic pig_xnum_t pig_xpow(input pig_xnum_t a, input int unsigned k);
    pig_xnum_t r;
    r = a;
    for (int unsigned i = 1; i < k; i++) begin
      r = pig_xmul(r, a);
    end
    return r;
  endfunction

  function automatic logic pig_xge(input pig_xnum_t a, input pig_xnum_t b);
    logic ge;
    if ($signed(a.e) != $signed(b.e)) begin
      ge = ($signed(a.e) > $signed(b.e));
    end else begin
      ge = (a.m >= b.m);
    end
    return ge;
  endfunction

  // Level o as a normalised ratio over the fixed denominator
  function automatic pig_xnum_t pig_level_ratio(input int unsigned o);
    longint unsigned n;
    int unsigned     k;
    pig_xnum_t       r;
    n = longint'(o) * 1000 + 14025;
    k = 0;
    while (((n << k) / GAM_RATIO_DEN) < MANT_MIN) begin
      k++;
    end
    r.m = 32'((n << k) / GAM_RATIO_DEN);
    r.e = -$signed(32'(k));
    return r;
  endfunction

  // idx / 2^g as a normalised ratio
  function automatic pig_xnum_t pig_index_ratio(input longint unsigned idx,
                                                input int unsigned g);
    int unsigned k;
    pig_xnum_t   r;
    k = 0;
    while (((idx << k) >> g) < MANT_MIN) begin
      k++;
    end
    r.m = 32'((idx << k) >> g);
    r.e = -$signed(32'(k));
    return r;
  endfunction

  // Smallest gamma index that reaches each level 1..255; entry 0 unused
  function automatic pig_thr_t pig_gamma_thresholds(input int unsigned g);
    pig_thr_t        thr;
    pig_xnum_t       tp;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    thr    = '0;
    for (int unsigned o = 1; o < 256; o++) begin
      tp = pig_xpow(pig_level_ratio(o), 12);
      lo = 1;
      hi = longint'(1) << g;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (pig_xge(pig_xpow(pig_index_ratio(mid, g), 5), tp)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      thr[o] = THR_W'(lo);
    end
    return thr;
  endfunction

endpackage

@@ rtl/pig_luma.sv @@
`timescale 1ns / 1ps

module pig_luma
  import pig_pkg::*;
#(
  parameter int unsigned LUMA_FRACTION_BITS = PIG_LUMA_FRACTION_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [PIX_W-1:0]              blue_i,
  input  logic [PIX_W-1:0]              green_i,
  input  logic [PIX_W-1:0]              red_i,
  output logic [LUMA_FRACTION_BITS:0]   luma_o
);

  localparam int unsigned F   = LUMA_FRACTION_BITS;
  localparam int unsigned S_W = F + 8;
  localparam int unsigned Y_W = F + 1;
  localparam int unsigned P_W = S_W + F + 1;

  localparam longint unsigned ONE    = longint'(1) << F;
  localparam longint unsigned W_RED  = (2126 * ONE + 5000) / 10000;
  localparam longint unsigned W_BLUE = (722 * ONE + 5000) / 10000;
  localparam longint unsigned W_GRN  = ONE - W_RED - W_BLUE;
  // floor(2^S_W / 255); at most one short of the true quotient
  localparam longint unsigned RECIP  = (longint'(1) << S_W) / 255;

  logic [S_W-1:0] sum_d,  sum_q;
  logic [P_W-1:0] prod_d, prod_q;
  logic [S_W-1:0] sum2_q;
  logic [Y_W-1:0] quot;
  logic [S_W-1:0] rem;
  logic [Y_W-1:0] luma_d, luma_q;

  // weighted sum, Q0.F times 255
  assign sum_d = S_W'(W_RED) * S_W'(red_i) + S_W'(W_GRN) * S_W'(green_i)
               + S_W'(W_BLUE) * S_W'(blue_i);

  assign prod_d = P_W'(sum_q) * P_W'(RECIP);

  // one-step correction of the reciprocal estimate
  assign quot   = Y_W'(prod_q >> S_W);
  assign rem    = sum2_q - ((S_W'(quot) << 8) - S_W'(quot));
  assign luma_d = quot + Y_W'(rem >= S_W'(255));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_d;
      prod_q <= prod_d;
      sum2_q <= sum_q;
      luma_q <= luma_d;
    end
  end

  assign luma_o = luma_q;

endmodule

@@ rtl/pig_encode.sv @@
`timescale 1ns / 1ps

module pig_encode
  import pig_pkg::*;
#(
  parameter int unsigned GAMMA_INDEX_BITS   = PIG_GAMMA_INDEX_BITS,
  parameter int unsigned LUMA_FRACTION_BITS = PIG_LUMA_FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [LUMA_FRACTION_BITS:0] luma_i,
  output logic [PIX_W-1:0]            gray_o
);

  localparam int unsigned F   = LUMA_FRACTION_BITS;
  localparam int unsigned G   = GAMMA_INDEX_BITS;
  localparam int unsigned Y_W = F + 1;
  localparam int unsigned N_W = Y_W + LIN_MUL_W;
  localparam int unsigned X_W = LIN_X_W + PIX_W;

  // largest Y still on the linear segment: Y * 10^7 <= 31308 * 2^F
  localparam longint unsigned LIN_MAX = (31308 * (longint'(1) << F)) / 10000000;
  localparam pig_thr_t        THR     = pig_gamma_thresholds(G);

  logic [N_W-1:0]     lin_prod;
  logic [F+G:0]       luma_sh;
  logic [LIN_X_W-1:0] lin_x_d, lin_x_q;
  logic               lin_d,   lin_q;
  logic [G:0]         idx_d,   idx_q;
  logic [X_W-1:0]     lin_div;
  logic [PIX_W-1:0]   lin_lvl;
  logic [PIX_W-1:0]   pow_lvl;

  assign lin_prod = N_W'(luma_i) * N_W'(LIN_MUL);
  assign lin_x_d  = LIN_X_W'(lin_prod >> F);
  assign lin_d    = (luma_i <= Y_W'(LIN_MAX));
  assign luma_sh  = {luma_i, {G{1'b0}}} >> F;
  assign idx_d    = luma_sh[G:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_x_q <= lin_x_d;
      lin_q   <= lin_d;
      idx_q   <= idx_d;
    end
  end

  // divide by five
  assign lin_div = X_W'(lin_x_q) * X_W'(DIV5_MUL);
  assign lin_lvl = PIX_W'(lin_div >> DIV5_SHIFT);

  // thresholds rise with level: binary search for the highest level reached
  always_comb begin
    logic [PIX_W-1:0] pos;
    logic [PIX_W-1:0] cand;
    pos = '0;
    for (int b = PIX_W - 1; b >= 0; b--) begin
      cand = pos | (PIX_W'(1) << b);
      if (THR[cand] <= THR_W'(idx_q)) begin
        pos = cand;
      end
    end
    pow_lvl = pos;
  end

  assign gray_o = lin_q ? lin_lvl : pow_lvl;

endmodule

@@ rtl/pixel_invert_or_srgb_gray_unit.sv @@
`timescale 1ns / 1ps
// An accepted request passes the input, luma, encode and output registers before m_axis.
// Throughput: one pixel per clock; all six register stages move together on one enable,
//   held only while the output register is full and m_axis_tready is low.
// Reset (rst_ni, async, active low): pipeline emptied, mode back to invert.
// Config: cfg_ready_o is always high; mode is sampled with each pixel on entry.

module pixel_invert_or_srgb_gray_unit
  import pig_pkg::*;
#(
  parameter int unsigned GAMMA_INDEX_BITS   = PIG_GAMMA_INDEX_BITS,  // 8..16
  parameter int unsigned LUMA_FRACTION_BITS = PIG_LUMA_FRACTION_BITS // 10..20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // blue_in [7:0], green_in [15:8], red_in [23:16]
  // pixel out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // blue_out [7:0], green_out [15:8], red_out [23:16]
  // mode register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i      // mode
);

  // stage 0 input, 1..3 luma, 4 encode, 5 output
  localparam int unsigned NSTG  = 6;
  localparam int unsigned SIDE_N = 4;

  typedef struct packed {
    pig_mode_e          mode;
    logic [TDATA_W-1:0] pix;
  } side_t;

  pig_mode_e          mode_q;
  logic [NSTG-1:0]    vld_q;
  logic               adv;
  side_t              in_q;
  side_t              side_q [SIDE_N];
  logic [PIX_W-1:0]   blue, green, red;
  logic [LUMA_FRACTION_BITS:0] luma;
  logic [PIX_W-1:0]   gray;
  logic [TDATA_W-1:0] out_d, out_q;

  // whole pipeline advances unless a finished result is held back
  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INVERT;
    end else if (cfg_valid_i) begin
      mode_q <= pig_mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.mode <= mode_q;
      in_q.pix  <= s_axis_tdata;
      side_q[0] <= in_q;
      for (int i = 1; i < SIDE_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
      out_q <= out_d;
    end
  end

  assign blue  = in_q.pix[PIX_W-1:0];
  assign green = in_q.pix[2*PIX_W-1:PIX_W];
  assign red   = in_q.pix[3*PIX_W-1:2*PIX_W];

  pig_luma #(
    .LUMA_FRACTION_BITS (LUMA_FRACTION_BITS)
  ) u_luma (
    .clk_i   (clk_i),
    .en_i    (adv),
    .blue_i  (blue),
    .green_i (green),
    .red_i   (red),
    .luma_o  (luma)
  );

  pig_encode #(
    .GAMMA_INDEX_BITS   (GAMMA_INDEX_BITS),
    .LUMA_FRACTION_BITS (LUMA_FRACTION_BITS)
  ) u_encode (
    .clk_i  (clk_i),
    .en_i   (adv),
    .luma_i (luma),
    .gray_o (gray)
  );

  // side stage SIDE_N-1 lines up with the encode register
  always_comb begin
    case (side_q[SIDE_N-1].mode)
      MODE_GRAY: out_d = {gray, gray, gray};
      default:   out_d = ~side_q[SIDE_N-1].pix;
    endcase
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = out_q;

endmodule

@@ dv/tb_pixel_invert_or_srgb_gray_unit.sv @@
`timescale 1ns / 1ps

module tb_pixel_invert_or_srgb_gray_unit;
  import pig_pkg::*;

  localparam int unsigned GB = PIG_GAMMA_INDEX_BITS;
  localparam int unsigned FB = PIG_LUMA_FRACTION_BITS;
  localparam longint unsigned LUMA_ONE = 64'd1 << FB;
  // Rec.709 weights in Q0.F; green takes the rounding slack so they sum to one
  localparam longint unsigned WT_RED   = (2126 * LUMA_ONE + 5000) / 10000;
  localparam longint unsigned WT_BLUE  = (722 * LUMA_ONE + 5000) / 10000;
  localparam longint unsigned WT_GREEN = LUMA_ONE - WT_RED - WT_BLUE;
  localparam int unsigned RANDOM_PIXELS = 1450;
  localparam int unsigned FIRST_PHASE   = 400;  // long enough to carry the hold-off
  localparam int unsigned HOLD_AFTER    = 300;  // results seen before the receiver holds off
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 6;    // pipeline depth, before a mode write
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef enum logic {
    REQ_PIXEL,
    REQ_MODE
  } req_kind_e;

  typedef struct {
    req_kind_e   kind;
    pix_t        pix;
    int unsigned gap;   // idle cycles before this request is offered
    pig_mode_e   mode;
  } stream_req_t;

  // mantissa in [2^31, 2^32) times 2^e
  typedef struct {
    logic [31:0] m;
    int          e;
  } fx_num_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               pix_valid = 1'b0;
  logic [TDATA_W-1:0] pix_data = '0;
  logic               out_ready = 1'b0;
  logic               mode_valid = 1'b0;
  logic               mode_data = 1'b0;
  logic               s_axis_tready;
  logic               m_axis_tvalid;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               cfg_ready_o;

  stream_req_t stream_plan[$];
  pix_t        expected_pixels[$];
  fx_num_t     level_pow12[256];
  pig_mode_e   mode_shadow;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned settle_count = 0;
  int unsigned stall_left = 0;
  int unsigned rx_calm = 0;
  int unsigned tx_calm = 0;
  int unsigned hold_count = 0;
  logic        rx_hold = 1'b0;

  pixel_invert_or_srgb_gray_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (pix_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (pix_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (mode_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (mode_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- normalised arithmetic for the gamma table ----------------

  function automatic fx_num_t fx_frac(input longint unsigned n, input longint unsigned d);
    fx_num_t r;
    int      k;
    k = 0;
    while (((n << k) / d) < 64'h8000_0000) k++;
    r.m = 32'((n << k) / d);
    r.e = -k;
    return r;
  endfunction

  function automatic fx_num_t fx_mul(input fx_num_t a, input fx_num_t b);
    logic [63:0] p;
    fx_num_t     r;
    p = {32'd0, a.m} * {32'd0, b.m};
    if (p[63]) begin
      r.m = p[63:32];
      r.e = a.e + b.e + 32;
    end else begin
      r.m = p[62:31];
      r.e = a.e + b.e + 31;
    end
    return r;
  endfunction

  function automatic fx_num_t fx_pow(input fx_num_t a, input int k);
    fx_num_t r;
    r = a;
    for (int i = 1; i < k; i++) r = fx_mul(r, a);
    return r;
  endfunction

  function automatic bit fx_ge(input fx_num_t a, input fx_num_t b);
    if (a.e != b.e) return a.e > b.e;
    return a.m >= b.m;
  endfunction

  // largest level whose 12th power of the normalised sRGB ratio is at most y^5
  function automatic logic [7:0] srgb_code(input longint unsigned idx);
    fx_num_t y5;
    int      lo;
    int      hi;
    int      mid;
    if (idx == 0) return 8'd0;
    y5 = fx_pow(fx_frac(idx, 64'd1 << GB), 5);
    if (!fx_ge(y5, level_pow12[0])) return 8'd0;
    lo = 0;
    hi = 256;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (fx_ge(y5, level_pow12[mid])) lo = mid;
      else hi = mid;
    end
    return 8'(lo);
  endfunction

  function automatic logic [7:0] luma_code(input pix_t p);
    longint unsigned s;
    longint unsigned y;
    longint unsigned v;
    s = WT_RED * p.red + WT_GREEN * p.green + WT_BLUE * p.blue;
    y = s / 255;
    // linear toe near black, power law above
    if (y * 10000000 <= 31308 * LUMA_ONE) begin
      v = (y * 255 * 1292) / (100 * LUMA_ONE);
      return (v > 255) ? 8'd255 : 8'(v);
    end
    return srgb_code((y << GB) >> FB);
  endfunction

  function automatic pix_t shade_pixel(input pix_t p, input pig_mode_e m);
    pix_t       q;
    logic [7:0] v;
    if (m == MODE_INVERT) begin
      q = ~p;
    end else begin
      v = luma_code(p);
      q = {v, v, v};
    end
    return q;
  endfunction

  // ---------------- stimulus plan ----------------

  // mostly short gaps, a few long ones, with stretches of back-to-back requests
  function automatic int unsigned tx_gap();
    int unsigned r;
    if (tx_calm != 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) tx_calm = $urandom_range(30, 120);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic add_pixel(input pix_t p);
    stream_req_t q;
    q.kind = REQ_PIXEL;
    q.pix  = p;
    q.gap  = tx_gap();
    q.mode = MODE_INVERT;
    stream_plan.push_back(q);
  endtask

  task automatic add_mode(input pig_mode_e m);
    stream_req_t q;
    q.kind = REQ_MODE;
    q.pix  = '0;
    q.gap  = 0;
    q.mode = m;
    stream_plan.push_back(q);
  endtask

  task automatic add_corners();
    add_pixel(24'h000000);
    add_pixel(24'hFFFFFF);  // full white hits the last gamma entry
    add_pixel(24'h0000FF);
    add_pixel(24'h00FF00);
    add_pixel(24'hFF0000);
    add_pixel(24'h00000B);  // blue only, last linear step
    add_pixel(24'h00000C);  // blue only, first power step
    add_pixel(24'h030000);  // red only, linear
    add_pixel(24'h040000);  // red only, power
    add_pixel(24'h010101);
    add_pixel(24'hFEFEFE);
    add_pixel(24'hA5C35A);
  endtask

  function automatic pix_t random_pixel();
    int unsigned r;
    logic [7:0]  v;
    r = $urandom_range(0, 9);
    if (r < 6) return pix_t'($urandom_range(0, 24'hFFFFFF));
    if (r < 8) return {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                       8'($urandom_range(0, 15))};
    v = 8'($urandom_range(0, 255));
    return {v, v, v};
  endfunction

  task automatic build_plan();
    int unsigned total;
    int unsigned len;
    int unsigned phase;
    add_corners();            // reset mode is invert
    add_mode(MODE_GRAY);
    add_corners();
    total = 0;
    phase = 0;
    while (total < RANDOM_PIXELS) begin
      if (phase == 1) add_mode(MODE_INVERT);
      else if (phase == 2) add_mode(MODE_GRAY);
      else if (phase > 2) add_mode(pig_mode_e'($urandom_range(0, 1)));
      len = (phase == 0) ? FIRST_PHASE : $urandom_range(100, 350);
      for (int unsigned i = 0; i < len && total < RANDOM_PIXELS; i++) begin
        add_pixel(random_pixel());
        total++;
      end
      phase++;
    end
  endtask

  // ---------------- driver: pixel stream and mode writes ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid    <= 1'b0;
      pix_data     <= '0;
      mode_valid   <= 1'b0;
      mode_data    <= 1'b0;
      mode_shadow  = MODE_INVERT;
      settle_count = 0;
      gap_left     = (stream_plan.size() != 0) ? stream_plan[0].gap : 0;
    end else begin
      if (pix_valid && s_axis_tready) begin
        // mode is taken with the pixel on entry
        expected_pixels.push_back(shade_pixel(stream_plan[0].pix, mode_shadow));
        void'(stream_plan.pop_front());
        gap_left = (stream_plan.size() != 0) ? stream_plan[0].gap : 0;
      end
      if (mode_valid && cfg_ready_o) begin
        mode_shadow = pig_mode_e'(mode_data);
        void'(stream_plan.pop_front());
        gap_left = (stream_plan.size() != 0) ? stream_plan[0].gap : 0;
        mode_valid <= 1'b0;
      end

      if (pix_valid && !s_axis_tready) begin
        // request held until taken
      end else if (mode_valid && !cfg_ready_o) begin
        // write held until taken
      end else if (stream_plan.size() == 0) begin
        pix_valid <= 1'b0;
      end else if (stream_plan[0].kind == REQ_PIXEL) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_valid <= 1'b0;
        end else begin
          pix_valid <= 1'b1;
          pix_data  <= stream_plan[0].pix;
        end
      end else begin
        // mode write only once the pipeline has drained
        pix_valid <= 1'b0;
        if (expected_pixels.size() == 0) settle_count++;
        else settle_count = 0;
        if (settle_count >= SETTLE_CYCLES) begin
          settle_count = 0;
          mode_valid <= 1'b1;
          mode_data  <= stream_plan[0].mode;
        end
      end
    end
  end

  // ---------------- receiver: long hold-off once traffic is flowing ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold    <= 1'b0;
      hold_count = 0;
    end else if (results_seen >= HOLD_AFTER && hold_count < HOLD_CYCLES) begin
      rx_hold <= 1'b1;
      hold_count++;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------- monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    pix_t        want;
    pix_t        got;
    int unsigned r;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      rx_calm    = 0;
    end else begin
      if (m_axis_tvalid && out_ready) begin
        results_seen++;
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          report("unrequested result", got.blue, 8'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.blue != want.blue) report("blue_out", got.blue, want.blue);
          if (got.green != want.green) report("green_out", got.green, want.green);
          if (got.red != want.red) report("red_out", got.red, want.red);
        end
      end

      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_calm != 0) begin
          rx_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) rx_calm = $urandom_range(50, 200);
          else if (r < 55) stall_left = 0;
          else if (r < 85) stall_left = $urandom_range(1, 3);
          else if (r < 97) stall_left = $urandom_range(4, 8);
          else stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int o = 0; o < 256; o++) begin
      level_pow12[o] = fx_pow(fx_frac(longint'(o) * 1000 + 14025, 269025), 12);
    end
    build_plan();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (stream_plan.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
